// ----- rtl/core/stsm_pkg.sv -----
// ----------------------------------------------------------------------------
// stsm_pkg
// Shared widths, defaults and the stored entry type of the triplet sort core.
// ----------------------------------------------------------------------------
package stsm_pkg;

   localparam int IDX_W           = 14;
   localparam int VAL_W           = 48;
   localparam int MAX_ENTRIES_DEF = 64;

   typedef struct packed {
      logic signed [IDX_W-1:0] row;
      logic signed [IDX_W-1:0] col;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   localparam logic signed [IDX_W-1:0] IDX_NONE = '1;
   localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

// ----- rtl/core/sparse_triplet_sort_merge_core.sv -----
// ----------------------------------------------------------------------------
// sparse_triplet_sort_merge_core
// Collects triplets, sorts them by row then column, sums duplicates, emits.
// ----------------------------------------------------------------------------
// Triplets are taken one per cycle into a single-port-write entry memory until
// a beat with last_in arrives; further triplets beyond MAX_ENTRIES are dropped
// and flagged. The set is then sorted in place by an insertion sequencer that
// moves one entry per cycle through the memory, merged and compacted through a
// read state and a process state per entry, and emitted through a read, an
// output and a wait state per result, holding in the wait state while the
// output is stalled. The input is stalled from the last_in beat until the
// final result is taken.
module sparse_triplet_sort_merge_core #(
   parameter int MAX_ENTRIES = stsm_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [stsm_pkg::IDX_W-1:0]   req_row,
   input  logic signed [stsm_pkg::IDX_W-1:0]   req_col,
   input  logic signed [stsm_pkg::VAL_W-1:0]   req_value,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [stsm_pkg::IDX_W-1:0]   rsp_out_row,
   output logic signed [stsm_pkg::IDX_W-1:0]   rsp_out_col,
   output logic signed [stsm_pkg::VAL_W-1:0]   rsp_out_value,
   output logic                                rsp_entry_valid,
   output logic                                rsp_overflow,
   output logic                                rsp_last_out
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

   typedef enum logic [3:0] {
      S_LOAD, S_SKEY, S_SKEYW, S_SCMP, S_SPUT,
      S_MRD, S_MPROC, S_ERD, S_EOUT, S_EWAIT
   } state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff, i_ff, j_ff, nout_ff, head_ff;
   logic ovf_ff, have_ff;
   stsm_pkg::entry_type key_ff, hd_ff, rd_ff;

   stsm_pkg::entry_type mem [MAX_ENTRIES];
   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   stsm_pkg::entry_type mem_wdata;

   logic key_before;
   logic signed [stsm_pkg::VAL_W:0] sum;
   logic sum_hi, sum_lo;
   stsm_pkg::entry_type req_e, merged;
   logic [CW-1:0] i_next, j_dec;

   assign req_e     = '{row: req_row, col: req_col, value: req_value};
   assign req_stall = (state_ff != S_LOAD);
   assign key_before = (key_ff.row != rd_ff.row) ? (key_ff.row < rd_ff.row)
                                                 : (key_ff.col < rd_ff.col);
   assign sum    = {hd_ff.value[stsm_pkg::VAL_W-1], hd_ff.value}
                 + {rd_ff.value[stsm_pkg::VAL_W-1], rd_ff.value};
   assign sum_hi = !sum[stsm_pkg::VAL_W] && sum[stsm_pkg::VAL_W-1];
   assign sum_lo = sum[stsm_pkg::VAL_W] && !sum[stsm_pkg::VAL_W-1];
   assign i_next = i_ff + CW'(1);
   assign j_dec  = j_ff - CW'(1);

   always_comb begin
      merged = hd_ff;
      priority if (sum_hi) begin
         merged.value = stsm_pkg::VAL_MAX;
      end else if (sum_lo) begin
         merged.value = stsm_pkg::VAL_MIN;
      end else begin
         merged.value = sum[stsm_pkg::VAL_W-1:0];
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff[AW-1:0];
      mem_wdata = req_e;
      mem_raddr = i_ff[AW-1:0];
      unique case (state_ff)
         S_LOAD: begin
            mem_we = req_valid && (cnt_ff < CNT_MAX);
         end
         S_SKEYW: begin
            mem_raddr = i_ff[AW-1:0] - AW'(1);
         end
         S_SCMP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[AW-1:0];
            mem_wdata = key_before ? rd_ff : key_ff;
            mem_raddr = j_dec[AW-1:0] - AW'(1);
         end
         S_SPUT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = key_ff;
         end
         S_MPROC: begin
            mem_waddr = nout_ff[AW-1:0];
            mem_wdata = rd_ff;
            if (rd_ff.row != stsm_pkg::IDX_NONE) begin
               mem_we = 1'b1;
               if (rd_ff.col != stsm_pkg::IDX_NONE && have_ff
                   && rd_ff.row == hd_ff.row && rd_ff.col == hd_ff.col) begin
                  mem_waddr = head_ff[AW-1:0];
                  mem_wdata = merged;
               end
            end
         end
         S_ERD: begin
            mem_raddr = i_ff[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         have_ff   <= 1'b0;
         rsp_valid <= 1'b0;
         i_ff      <= '0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (cnt_ff < CNT_MAX) begin
                     cnt_ff <= cnt_ff + CW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last_in) begin
                     i_ff <= CW'(1);
                     if (cnt_ff == '0) begin
                        i_ff     <= '0;
                        nout_ff  <= '0;
                        have_ff  <= 1'b0;
                        state_ff <= S_MRD;
                     end else begin
                        state_ff <= S_SKEY;
                     end
                  end
               end
            end
            S_SKEY: begin
               state_ff <= S_SKEYW;
            end
            S_SKEYW: begin
               key_ff   <= rd_ff;
               j_ff     <= i_ff;
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (key_before) begin
                  j_ff <= j_dec;
                  if (j_dec == '0) begin
                     state_ff <= S_SPUT;
                  end
               end else begin
                  i_ff     <= i_next;
                  state_ff <= S_SKEY;
                  if (i_next == cnt_ff) begin
                     i_ff     <= '0;
                     nout_ff  <= '0;
                     have_ff  <= 1'b0;
                     state_ff <= S_MRD;
                  end
               end
            end
            S_SPUT: begin
               i_ff     <= i_next;
               state_ff <= S_SKEY;
               if (i_next == cnt_ff) begin
                  i_ff     <= '0;
                  nout_ff  <= '0;
                  have_ff  <= 1'b0;
                  state_ff <= S_MRD;
               end
            end
            S_MRD: begin
               state_ff <= S_MPROC;
            end
            S_MPROC: begin
               if (rd_ff.row != stsm_pkg::IDX_NONE) begin
                  if (rd_ff.col == stsm_pkg::IDX_NONE) begin
                     nout_ff <= nout_ff + CW'(1);
                  end else if (have_ff && rd_ff.row == hd_ff.row
                               && rd_ff.col == hd_ff.col) begin
                     hd_ff <= merged;
                     if (sum_hi || sum_lo) begin
                        ovf_ff <= 1'b1;
                     end
                  end else begin
                     hd_ff   <= rd_ff;
                     have_ff <= 1'b1;
                     head_ff <= nout_ff;
                     nout_ff <= nout_ff + CW'(1);
                  end
               end
               i_ff     <= i_next;
               state_ff <= S_MRD;
               if (i_next == cnt_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_ERD;
               end
            end
            S_ERD: begin
               state_ff <= S_EOUT;
            end
            S_EOUT: begin
               rsp_valid    <= 1'b1;
               rsp_overflow <= ovf_ff;
               if (nout_ff == '0) begin
                  rsp_out_row     <= '0;
                  rsp_out_col     <= '0;
                  rsp_out_value   <= '0;
                  rsp_entry_valid <= 1'b0;
                  rsp_last_out    <= 1'b1;
               end else begin
                  rsp_out_row     <= rd_ff.row;
                  rsp_out_col     <= rd_ff.col;
                  rsp_out_value   <= rd_ff.value;
                  rsp_entry_valid <= 1'b1;
                  rsp_last_out    <= (i_next == nout_ff);
               end
               state_ff <= S_EWAIT;
            end
            S_EWAIT: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  if (rsp_last_out) begin
                     cnt_ff   <= '0;
                     ovf_ff   <= 1'b0;
                     i_ff     <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     i_ff     <= i_next;
                     state_ff <= S_ERD;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

endmodule

// ----- dv/sparse_triplet_sort_merge_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_triplet_sort_merge_checker
// Watches both channels of the triplet sort core, predicts the sorted and
// merged entry list of every set and compares each response beat against it.
// ----------------------------------------------------------------------------
module sparse_triplet_sort_merge_checker #(
   parameter int MAX_ENTRIES = stsm_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [stsm_pkg::IDX_W-1:0]   req_row,
   input  logic signed [stsm_pkg::IDX_W-1:0]   req_col,
   input  logic signed [stsm_pkg::VAL_W-1:0]   req_value,
   input  logic                                req_last_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [stsm_pkg::IDX_W-1:0]   rsp_out_row,
   input  logic signed [stsm_pkg::IDX_W-1:0]   rsp_out_col,
   input  logic signed [stsm_pkg::VAL_W-1:0]   rsp_out_value,
   input  logic                                rsp_entry_valid,
   input  logic                                rsp_overflow,
   input  logic                                rsp_last_out,
   output int                                  error_count,
   output int                                  pending_count
);

   typedef struct {
      logic signed [stsm_pkg::IDX_W-1:0] row;
      logic signed [stsm_pkg::IDX_W-1:0] col;
      logic signed [stsm_pkg::VAL_W-1:0] value;
      logic                              entry_valid;
      logic                              overflow;
      logic                              last_out;
   } merged_beat_type;

   stsm_pkg::entry_type set_entries[$];
   logic                set_dropped;
   merged_beat_type     merged_q[$];

   assign pending_count = merged_q.size();

   function automatic bit sorts_first(stsm_pkg::entry_type a, stsm_pkg::entry_type b);
      if (a.row != b.row) return a.row < b.row;
      return a.col < b.col;
   endfunction

   task automatic predict_merged_set();
      stsm_pkg::entry_type sorted[$];
      merged_beat_type     outs[$];
      merged_beat_type     mb;
      stsm_pkg::entry_type e;
      logic                ovf;
      int                  j;
      int                  head;
      logic signed [stsm_pkg::VAL_W:0] sum;
      ovf  = set_dropped;
      head = -1;
      foreach (set_entries[i]) begin
         e = set_entries[i];
         j = sorted.size();
         while (j > 0 && sorts_first(e, sorted[j-1])) j--;
         sorted.insert(j, e);
      end
      foreach (sorted[i]) begin
         e = sorted[i];
         if (e.row == stsm_pkg::IDX_NONE) continue;
         if (e.col != stsm_pkg::IDX_NONE && head >= 0 && outs[head].row == e.row &&
             outs[head].col == e.col) begin
            sum = {outs[head].value[stsm_pkg::VAL_W-1], outs[head].value}
                + {e.value[stsm_pkg::VAL_W-1], e.value};
            if (sum > $signed({stsm_pkg::VAL_MAX[stsm_pkg::VAL_W-1], stsm_pkg::VAL_MAX})) begin
               outs[head].value = stsm_pkg::VAL_MAX;
               ovf = 1'b1;
            end else if (sum < $signed({stsm_pkg::VAL_MIN[stsm_pkg::VAL_W-1],
                                        stsm_pkg::VAL_MIN})) begin
               outs[head].value = stsm_pkg::VAL_MIN;
               ovf = 1'b1;
            end else begin
               outs[head].value = sum[stsm_pkg::VAL_W-1:0];
            end
            continue;
         end
         mb.row = e.row;
         mb.col = e.col;
         mb.value = e.value;
         mb.entry_valid = 1'b1;
         mb.overflow = 1'b0;
         mb.last_out = 1'b0;
         outs.push_back(mb);
         if (e.col != stsm_pkg::IDX_NONE) head = outs.size() - 1;
      end
      if (outs.size() == 0) begin
         mb.row = '0;
         mb.col = '0;
         mb.value = '0;
         mb.entry_valid = 1'b0;
         outs.push_back(mb);
      end
      outs[outs.size()-1].last_out = 1'b1;
      foreach (outs[i]) begin
         outs[i].overflow = ovf;
         merged_q.push_back(outs[i]);
      end
      set_entries.delete();
      set_dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      merged_beat_type     exp_b;
      stsm_pkg::entry_type e;
      if (reset) begin
         set_entries.delete();
         set_dropped = 1'b0;
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (merged_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat row=%0d col=%0d value=%0d", $time,
                        rsp_out_row, rsp_out_col, rsp_out_value);
            end else begin
               exp_b = merged_q.pop_front();
               if (rsp_out_row !== exp_b.row || rsp_out_col !== exp_b.col ||
                   rsp_out_value !== exp_b.value ||
                   rsp_entry_valid !== exp_b.entry_valid ||
                   rsp_overflow !== exp_b.overflow || rsp_last_out !== exp_b.last_out) begin
                  error_count++;
                  $display("%0t: mismatch expected row=%0d col=%0d value=%0d ev=%b ovf=%b last=%b",
                           $time, exp_b.row, exp_b.col, exp_b.value, exp_b.entry_valid,
                           exp_b.overflow, exp_b.last_out);
                  $display("%0t:          actual row=%0d col=%0d value=%0d ev=%b ovf=%b last=%b",
                           $time, rsp_out_row, rsp_out_col, rsp_out_value, rsp_entry_valid,
                           rsp_overflow, rsp_last_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (set_entries.size() < MAX_ENTRIES) begin
               e.row = req_row;
               e.col = req_col;
               e.value = req_value;
               set_entries.push_back(e);
            end else begin
               set_dropped = 1'b1;
            end
            if (req_last_in) predict_merged_set();
         end
      end
   end

endmodule

// ----- dv/tb_sparse_triplet_sort_merge_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_triplet_sort_merge_core
// Drives triplet sets into the sort and merge core: directed corner sets, then
// random sets with heavy coordinate reuse, random idling on both sides and a
// long response hold-off; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_sparse_triplet_sort_merge_core;

   localparam int  LIMIT_CYCLES = 3000000;
   localparam int  RANDOM_ITEMS = 220;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [stsm_pkg::IDX_W-1:0] req_row = '0;
   logic signed [stsm_pkg::IDX_W-1:0] req_col = '0;
   logic signed [stsm_pkg::VAL_W-1:0] req_value = '0;
   logic                              req_last_in = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [stsm_pkg::IDX_W-1:0] rsp_out_row;
   logic signed [stsm_pkg::IDX_W-1:0] rsp_out_col;
   logic signed [stsm_pkg::VAL_W-1:0] rsp_out_value;
   logic                              rsp_entry_valid;
   logic                              rsp_overflow;
   logic                              rsp_last_out;
   int                                error_count;
   int                                pending_count;
   int                                cycle_count = 0;
   bit                                idle_enable = 1'b1;
   bit                                hold_off = 1'b0;

   always #1 clock = ~clock;

   sparse_triplet_sort_merge_core u_dut (.*);

   sparse_triplet_sort_merge_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response stall: random bursts, plus one long hold-off
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_triplet(logic signed [stsm_pkg::IDX_W-1:0] r,
                               logic signed [stsm_pkg::IDX_W-1:0] c,
                               logic signed [stsm_pkg::VAL_W-1:0] v, logic last);
      int n;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_row     <= r;
      req_col     <= c;
      req_value   <= v;
      req_last_in <= last;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [stsm_pkg::IDX_W-1:0] pick_index(int span);
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) return stsm_pkg::IDX_NONE;
      if (k == 1) return $signed(stsm_pkg::IDX_W'($urandom));
      if (k == 2) return 14'sd8191;
      return stsm_pkg::IDX_W'($urandom_range(0, span));
   endfunction

   function automatic logic signed [stsm_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return stsm_pkg::VAL_MAX - stsm_pkg::VAL_W'($urandom_range(0, 3));
         1: return stsm_pkg::VAL_MIN + stsm_pkg::VAL_W'($urandom_range(0, 3));
         2: return $signed(stsm_pkg::VAL_W'({$urandom, $urandom}));
         default: return $signed(stsm_pkg::VAL_W'($urandom_range(0, 2000))
                                 - stsm_pkg::VAL_W'(1000));
      endcase
   endfunction

   task automatic send_random_set(int len, int span);
      for (int i = 0; i < len; i++)
         send_triplet(pick_index(span), pick_index(span), pick_value(), i == len - 1);
   endtask

   initial begin
      int sent;
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed sets
      send_triplet(14'sd5, 14'sd3, 48'sd100, 1'b0);
      send_triplet(14'sd5, 14'sd3, 48'sd23, 1'b0);
      send_triplet(-14'sd1, 14'sd0, 48'sd7, 1'b0);
      send_triplet(14'sd2, -14'sd1, 48'sd9, 1'b0);
      send_triplet(14'sd2, -14'sd1, 48'sd4, 1'b0);
      send_triplet(-14'sd2, -14'sd8192, 48'sd1, 1'b0);
      send_triplet(14'sd8191, 14'sd8191, stsm_pkg::VAL_MIN, 1'b1);
      send_triplet(14'sd1, 14'sd1, stsm_pkg::VAL_MAX, 1'b0);
      send_triplet(14'sd1, 14'sd1, stsm_pkg::VAL_MAX, 1'b0);
      send_triplet(14'sd0, 14'sd0, stsm_pkg::VAL_MIN, 1'b0);
      send_triplet(14'sd0, 14'sd0, -48'sd1, 1'b1);
      send_triplet(-14'sd1, 14'sd4, 48'sd1, 1'b1);
      send_triplet(14'sd0, 14'sd0, 48'sd0, 1'b1);
      send_triplet(14'sd1, 14'sd0, -48'sd5, 1'b0);
      send_triplet(14'sd0, 14'sd1, 48'sd5, 1'b1);
      // overflowing set, with the long hold-off running
      hold_off = 1'b1;
      for (int i = 0; i < 70; i++)
         send_triplet(stsm_pkg::IDX_W'($urandom_range(0, 6)),
                      stsm_pkg::IDX_W'($urandom_range(0, 6)), pick_value(), i == 69);
      // random sets
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent > RANDOM_ITEMS - 60) idle_enable = 1'b0;
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
         send_random_set(len, ($urandom_range(0, 1) == 0) ? 3 : 8191);
         sent += len;
      end
      req_valid <= 1'b0;
      idle_enable = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
